### design/eight_bit_alu_with_flags_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the eight-bit ALU block
// Shared helpers for the port-level checker; clock and reset come from the
// scope that uses them.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_UNIT_DEFINES_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_UNIT_DEFINES_SVH

// Consequent must hold on the same edge as the antecedent.
`define EALU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ealu check failed: same-cycle rule");

// Consequent must hold once the antecedent has passed both pipeline registers.
`define EALU_ASSERT_LAT2(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error("ealu check failed: two-cycle rule");

`endif

### design/ealu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ealu_pkg
// Types and codes shared by the eight-bit ALU and its checker.
// ----------------------------------------------------------------------------
package ealu_pkg;

   localparam int unsigned DATA_W  = 8;
   localparam int unsigned CMD_W   = 4;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned FLAGS_W = 4;

   // flag positions within the flag nibble
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   localparam logic [3:0]        NIBBLE_MAX = 4'hF;
   localparam logic [DATA_W-1:0] DATA_ONE   = 8'h01;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 4'd0,
      CMD_SUB = 4'd1,
      CMD_CMP = 4'd2,
      CMD_XOR = 4'd3,
      CMD_INC = 4'd4,
      CMD_DEC = 4'd5,
      CMD_BIT = 4'd6,
      CMD_RL  = 4'd7,
      CMD_RLA = 4'd8
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [DATA_W-1:0]  operand_a;
      logic [DATA_W-1:0]  operand_b;
      logic [IDX_W-1:0]   bit_index;
      logic [FLAGS_W-1:0] flags_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  result;
      logic               write_back;
      logic [FLAGS_W-1:0] flags_out;
   } rsp_type;

endpackage

### design/ealu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ealu_core
// Single-pass datapath: add and subtract paths, increment/decrement, logic op,
// rotate and bit test, plus Z/N/H/C flag generation.
// ----------------------------------------------------------------------------
module ealu_core (
   input  ealu_pkg::req_type req,
   output ealu_pkg::rsp_type rsp
);

   logic [ealu_pkg::DATA_W:0]   sum;
   logic [ealu_pkg::DATA_W:0]   diff;
   logic [4:0]                  half_sum;
   logic [4:0]                  half_diff;
   logic [ealu_pkg::DATA_W-1:0] inc_val;
   logic [ealu_pkg::DATA_W-1:0] dec_val;
   logic [ealu_pkg::DATA_W-1:0] xor_val;
   logic [ealu_pkg::DATA_W-1:0] rot_val;
   logic                        cin;
   logic                        tested;

   assign cin       = req.flags_in[ealu_pkg::FLAG_C];
   assign sum       = {1'b0, req.operand_a} + {1'b0, req.operand_b};
   assign diff      = {1'b0, req.operand_a} - {1'b0, req.operand_b};
   assign half_sum  = {1'b0, req.operand_a[3:0]} + {1'b0, req.operand_b[3:0]};
   assign half_diff = {1'b0, req.operand_a[3:0]} - {1'b0, req.operand_b[3:0]};
   assign inc_val   = req.operand_a + ealu_pkg::DATA_ONE;
   assign dec_val   = req.operand_a - ealu_pkg::DATA_ONE;
   assign xor_val   = req.operand_a ^ req.operand_b;
   assign rot_val   = {req.operand_a[ealu_pkg::DATA_W-2:0], cin};
   assign tested    = req.operand_a[req.bit_index];

   always_comb begin
      // unused codes pass operand and flags through untouched
      rsp.result     = req.operand_a;
      rsp.write_back = 1'b0;
      rsp.flags_out  = req.flags_in;
      unique case (req.command)
         ealu_pkg::CMD_ADD: begin
            rsp.result     = sum[ealu_pkg::DATA_W-1:0];
            rsp.write_back = 1'b1;
            rsp.flags_out  = {sum[ealu_pkg::DATA_W-1:0] == '0, 1'b0, half_sum[4],
                              sum[ealu_pkg::DATA_W]};
         end
         ealu_pkg::CMD_SUB: begin
            rsp.result     = diff[ealu_pkg::DATA_W-1:0];
            rsp.write_back = 1'b1;
            rsp.flags_out  = {diff[ealu_pkg::DATA_W-1:0] == '0, 1'b1, half_diff[4],
                              diff[ealu_pkg::DATA_W]};
         end
         ealu_pkg::CMD_CMP: begin
            rsp.flags_out  = {diff[ealu_pkg::DATA_W-1:0] == '0, 1'b1, half_diff[4],
                              diff[ealu_pkg::DATA_W]};
         end
         ealu_pkg::CMD_XOR: begin
            rsp.result     = xor_val;
            rsp.write_back = 1'b1;
            rsp.flags_out  = {xor_val == '0, 3'b000};
         end
         ealu_pkg::CMD_INC: begin
            rsp.result     = inc_val;
            rsp.write_back = 1'b1;
            rsp.flags_out  = {inc_val == '0, 1'b0, inc_val[3:0] == 4'h0, cin};
         end
         ealu_pkg::CMD_DEC: begin
            rsp.result     = dec_val;
            rsp.write_back = 1'b1;
            rsp.flags_out  = {dec_val == '0, 1'b1, dec_val[3:0] == ealu_pkg::NIBBLE_MAX,
                              cin};
         end
         ealu_pkg::CMD_BIT: begin
            rsp.flags_out  = {~tested, 1'b0, 1'b1, cin};
         end
         ealu_pkg::CMD_RL: begin
            rsp.result     = rot_val;
            rsp.write_back = 1'b1;
            rsp.flags_out  = {rot_val == '0, 2'b00, req.operand_a[ealu_pkg::DATA_W-1]};
         end
         ealu_pkg::CMD_RLA: begin
            // accumulator form always clears Z
            rsp.result     = rot_val;
            rsp.write_back = 1'b1;
            rsp.flags_out  = {3'b000, req.operand_a[ealu_pkg::DATA_W-1]};
         end
         default: begin
            rsp.result     = req.operand_a;
            rsp.write_back = 1'b0;
            rsp.flags_out  = req.flags_in;
         end
      endcase
   end

endmodule

### design/eight_bit_alu_with_flags_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_unit
// Eight-bit ALU with Z/N/H/C flags: input register, single-pass datapath,
// result register.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  request   start / busy          req_command, req_operand_a, req_operand_b,
//                                  req_bit_index, req_flags_in
//  response  rsp_valid (strobe)    rsp_result, rsp_write_back, rsp_flags_out
//
//  One beat accepted per cycle while busy is low; the result strobes once
//  it has passed the input and result registers around one adder stage.
//  busy is high only while reset is asserted; the receiver cannot stall, so
//  every result is shown for exactly one cycle.
//  Reset is synchronous and clears both valid registers.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ealu_pkg::CMD_W-1:0]         req_command,
   input  logic [ealu_pkg::DATA_W-1:0]        req_operand_a,
   input  logic [ealu_pkg::DATA_W-1:0]        req_operand_b,
   input  logic [ealu_pkg::IDX_W-1:0]         req_bit_index,
   input  logic [ealu_pkg::FLAGS_W-1:0]       req_flags_in,
   output logic                               rsp_valid,
   output logic [ealu_pkg::DATA_W-1:0]        rsp_result,
   output logic                               rsp_write_back,
   output logic [ealu_pkg::FLAGS_W-1:0]       rsp_flags_out
);

   ealu_pkg::req_type req_ff;
   ealu_pkg::req_type req_in;
   logic              req_vld_ff;
   logic              req_vld_in;
   ealu_pkg::rsp_type rsp_ff;
   ealu_pkg::rsp_type rsp_in;
   logic              rsp_vld_ff;
   logic              rsp_vld_in;
   logic              accept;

   assign busy       = reset;
   assign accept     = start & ~busy;
   assign req_vld_in = accept;
   assign req_in     = '{command:   req_command,
                         operand_a: req_operand_a,
                         operand_b: req_operand_b,
                         bit_index: req_bit_index,
                         flags_in:  req_flags_in};
   assign rsp_vld_in = req_vld_ff;

   ealu_core u_core (
      .req (req_ff),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload: capture the beat only when it is live
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      if (req_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_result     = rsp_ff.result;
   assign rsp_write_back = rsp_ff.write_back;
   assign rsp_flags_out  = rsp_ff.flags_out;

endmodule

### design/ealu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ealu_checker
// Port-level checks on latency, strobe origin and selected flag rules.
// ----------------------------------------------------------------------------
`include "eight_bit_alu_with_flags_unit_defines.svh"

module ealu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic [ealu_pkg::CMD_W-1:0]         req_command,
   input logic                               rsp_valid,
   input logic [ealu_pkg::DATA_W-1:0]        rsp_result,
   input logic                               rsp_write_back,
   input logic [ealu_pkg::FLAGS_W-1:0]       rsp_flags_out
);

   logic accept;
   logic no_store_cmd;
   logic add_cmd;

   assign accept       = start & ~busy;
   assign no_store_cmd = (req_command == ealu_pkg::CMD_CMP) ||
                         (req_command == ealu_pkg::CMD_BIT);
   assign add_cmd      = (req_command == ealu_pkg::CMD_ADD);

   // every accepted beat strobes a result once it has passed both registers
   `EALU_ASSERT_LAT2(a_latency, accept, rsp_valid)
   // a strobe never appears without an accepted beat that has passed both registers
   `EALU_ASSERT_NOW(a_no_spurious, rsp_valid, $past(accept, 2))
   // compare and bit test never store
   `EALU_ASSERT_LAT2(a_no_store, accept && no_store_cmd, !rsp_write_back)
   // add: Z follows the result and N is clear
   `EALU_ASSERT_LAT2(a_add_flags, accept && add_cmd,
      (rsp_flags_out[ealu_pkg::FLAG_Z] == (rsp_result == '0)) && !rsp_flags_out[ealu_pkg::FLAG_N])

endmodule

bind eight_bit_alu_with_flags_unit ealu_checker u_ealu_checker (.*);
